// File: hdl/sync_marker_bit_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_MARKER_BIT_DEFRAMER_DEFINES_SVH
`define SYNC_MARKER_BIT_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define SMD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the same edge.
`define SMD_ASSERT_IMPL(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error(msg);

`else

`define SMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMD_ASSERT_IMPL(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

// File: hdl/smd_pkg.sv
// Package of types, constants and helper functions for the sync marker deframer.
package smd_pkg;

	localparam int unsigned PatternWidth = 64;
	localparam int unsigned CountWidth   = 19;
	localparam int unsigned FillWidth    = 16;
	localparam int unsigned ErrWidth     = 7;

	localparam logic [63:0] SyncPatternReset   = 64'h0218_a7a3_92dd_9abf;
	localparam logic [3:0]  SyncBytesReset     = 4'd8;
	localparam logic [5:0]  MaxMismatchesReset = 6'd9;
	localparam logic [15:0] FrameBytesReset    = 16'd15210;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SYNC_PATTERN   = 2'd0,
		CFG_SYNC_BYTES     = 2'd1,
		CFG_MAX_MISMATCHES = 2'd2,
		CFG_FRAME_BYTES    = 2'd3
	} cfg_index_t;

	// Result kinds.
	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_FILL = 1'b1
	} kind_t;

	// Results caused by one bit: header bytes, then an optional byte, then an
	// optional zero-fill record.
	typedef struct packed {
		logic [3:0]           hdr_cnt;
		logic                 has_byte;
		logic [7:0]           data_val;
		logic                 byte_end;
		logic                 has_fill;
		logic [FillWidth-1:0] fill;
	} desc_t;

	function automatic logic [ErrWidth-1:0] popcount64(input logic [PatternWidth-1:0] v);
		logic [ErrWidth-1:0] acc;
		acc = '0;
		for (int i = 0; i < PatternWidth; i++) begin
			acc = acc + ErrWidth'(v[i]);
		end
		return acc;
	endfunction

endpackage

// File: hdl/sync_marker_bit_deframer.sv
// Sync marker frame synchronizer that turns a serial bit stream into frame bytes.
// Path: stage 1 registers the bit; its results pass the result buffer and the output register.
// Throughput: one bit per cycle; the header burst of up to nine results drains at
// one result per cycle, unless stalled, from a one-entry result buffer, stalling
// the bit input only when a later bit also produces results before that buffer empties.
// Reset: control and frame state clear at once, registers load their defaults.
module sync_marker_bit_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        bit_valid,
	output logic        bit_stall,
	input  logic        data_bit,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [15:0] fill_zero_bytes,
	output logic        frame_end,
	output logic        cut_short
);

`include "sync_marker_bit_deframer_defines.svh"

	// Configuration registers.
	logic [63:0] sync_pattern_q;
	logic [3:0]  sync_bytes_q;
	logic [5:0]  max_mismatches_q;
	logic [15:0] frame_bytes_q;

	// The window shifts as each bit is accepted, so together with the stage 1
	// valid and bit it forms the input register of the processing stage.
	logic [63:0] sync_window_q;
	logic        valid_s1;
	logic        bit_s1;

	// Frame state.
	logic                              in_frame_q;
	logic [smd_pkg::CountWidth-1:0]    frame_bit_count_q;
	logic [7:0]                        byte_acc_q;
	logic [2:0]                        bits_in_byte_q;

	// Result buffer and output register.
	smd_pkg::desc_t desc_q;
	logic           result_valid_q;

	// Effective marker and frame lengths. A zero marker length acts as one byte
	// and anything above eight as eight; a frame not longer than the marker
	// gets one byte of payload.
	logic [3:0]                        sb;
	logic [15:0]                       fb;
	logic [smd_pkg::CountWidth-1:0]    fbits;
	logic [6:0]                        sb_bits;
	logic [63:0]                       mask;
	logic [smd_pkg::ErrWidth-1:0]      errs;
	logic                              match;

	always_comb begin
		priority if (sync_bytes_q == 4'd0) begin
			sb = 4'd1;
		end else if (sync_bytes_q > 4'd8) begin
			sb = 4'd8;
		end else begin
			sb = sync_bytes_q;
		end
		fb      = (frame_bytes_q <= {12'b0, sb}) ? ({12'b0, sb} + 16'd1) : frame_bytes_q;
		fbits   = {fb, 3'b000};
		sb_bits = {sb, 3'b000};
		for (int i = 0; i < 64; i++) begin
			mask[i] = (7'(i) < sb_bits);
		end
		errs  = smd_pkg::popcount64((sync_window_q ^ sync_pattern_q) & mask);
		match = (errs <= {1'b0, max_mismatches_q});
	end

	// Processing of the bit in stage 1: next frame state and the results it causes.
	logic                              in_frame_d;
	logic [smd_pkg::CountWidth-1:0]    frame_bit_count_d;
	logic [7:0]                        byte_acc_d;
	logic [2:0]                        bits_in_byte_d;
	smd_pkg::desc_t                    desc_new;

	logic [smd_pkg::CountWidth-1:0]    cnt0;
	logic [7:0]                        acc0;
	logic [2:0]                        bib0;
	logic [7:0]                        acc1;
	logic [3:0]                        bib1;
	logic [smd_pkg::CountWidth-1:0]    cnt1;
	logic [smd_pkg::CountWidth-1:0]    used;
	logic [smd_pkg::CountWidth-1:0]    missing;
	logic                              frame_done;

	always_comb begin
		in_frame_d        = in_frame_q;
		frame_bit_count_d = frame_bit_count_q;
		byte_acc_d        = byte_acc_q;
		bits_in_byte_d    = bits_in_byte_q;
		desc_new          = '0;

		// The first frame bit first places the clean header.
		if (frame_bit_count_q == '0) begin
			cnt0 = {12'b0, sb_bits};
			acc0 = 8'd0;
			bib0 = 3'd0;
		end else begin
			cnt0 = frame_bit_count_q;
			acc0 = byte_acc_q;
			bib0 = bits_in_byte_q;
		end
		acc1       = {acc0[6:0], bit_s1};
		bib1       = {1'b0, bib0} + 4'd1;
		cnt1       = cnt0 + 19'd1;
		frame_done = (cnt1 >= fbits);
		used       = cnt0 + ((bib0 != 3'd0) ? (19'd8 - {16'b0, bib0}) : 19'd0);
		missing    = (used < fbits) ? (fbits - used) : '0;

		if (!in_frame_q) begin
			if (match) begin
				in_frame_d = 1'b1;
			end
		end else begin
			desc_new.hdr_cnt = (frame_bit_count_q == '0) ? sb : 4'd0;
			if (match) begin
				// A marker inside the frame cuts it short; the marker bit is dropped.
				desc_new.has_byte = (bib0 != 3'd0);
				desc_new.data_val = acc0 << (4'd8 - {1'b0, bib0});
				desc_new.has_fill = 1'b1;
				desc_new.fill     = missing[smd_pkg::CountWidth-1:3];
				frame_bit_count_d = '0;
				byte_acc_d        = 8'd0;
				bits_in_byte_d    = 3'd0;
			end else begin
				if (bib1 == 4'd8) begin
					desc_new.has_byte = 1'b1;
					desc_new.data_val = acc1;
					desc_new.byte_end = frame_done;
				end else if (frame_done) begin
					// Short last byte goes out zero padded.
					desc_new.has_byte = 1'b1;
					desc_new.data_val = acc1 << (4'd8 - bib1);
					desc_new.byte_end = 1'b1;
				end
				if (frame_done) begin
					in_frame_d        = 1'b0;
					frame_bit_count_d = '0;
					byte_acc_d        = 8'd0;
					bits_in_byte_d    = 3'd0;
				end else begin
					frame_bit_count_d = cnt1;
					byte_acc_d        = (bib1 == 4'd8) ? 8'd0 : acc1;
					bits_in_byte_d    = bib1[2:0];
				end
			end
		end
	end

	// Result buffer sequencing: header bytes from the top down, then the data
	// byte, then the zero-fill record.
	logic       pending;
	logic       last_item;
	logic       out_load;
	logic       slot_free;
	logic       new_empty;
	logic       adv_s1;
	logic       accept;
	logic       push;
	logic [2:0] hdr_idx;
	logic       item_kind;
	logic [7:0] item_byte;
	logic [15:0] item_fill;
	logic       item_end;
	logic       item_cut;

	always_comb begin
		pending   = (desc_q.hdr_cnt != 4'd0) || desc_q.has_byte || desc_q.has_fill;
		last_item = ((desc_q.hdr_cnt == 4'd1) && !desc_q.has_byte && !desc_q.has_fill)
			|| ((desc_q.hdr_cnt == 4'd0) && !(desc_q.has_byte && desc_q.has_fill));
		out_load  = !result_valid_q || !result_stall;
		slot_free = !pending || (out_load && last_item);
		new_empty = (desc_new.hdr_cnt == 4'd0) && !desc_new.has_byte && !desc_new.has_fill;
		adv_s1    = valid_s1 && (new_empty || slot_free);
		push      = adv_s1 && !new_empty;
		bit_stall = valid_s1 && !adv_s1;
		accept    = bit_valid && !bit_stall;

		hdr_idx   = 3'(desc_q.hdr_cnt - 4'd1);
		item_kind = smd_pkg::KIND_DATA;
		item_byte = 8'd0;
		item_fill = 16'd0;
		item_end  = 1'b0;
		item_cut  = 1'b0;
		priority if (desc_q.hdr_cnt != 4'd0) begin
			item_byte = sync_pattern_q[{hdr_idx, 3'b000} +: 8];
		end else if (desc_q.has_byte) begin
			item_byte = desc_q.data_val;
			item_end  = desc_q.byte_end;
		end else begin
			item_kind = smd_pkg::KIND_FILL;
			item_fill = desc_q.fill;
			item_end  = 1'b1;
			item_cut  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q    <= smd_pkg::SyncPatternReset;
			sync_bytes_q      <= smd_pkg::SyncBytesReset;
			max_mismatches_q  <= smd_pkg::MaxMismatchesReset;
			frame_bytes_q     <= smd_pkg::FrameBytesReset;
			sync_window_q     <= '0;
			valid_s1          <= 1'b0;
			bit_s1            <= 1'b0;
			in_frame_q        <= 1'b0;
			frame_bit_count_q <= '0;
			byte_acc_q        <= 8'd0;
			bits_in_byte_q    <= 3'd0;
			desc_q            <= '0;
			result_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (smd_pkg::cfg_index_t'(cfg_index))
					smd_pkg::CFG_SYNC_PATTERN:   sync_pattern_q   <= cfg_data;
					smd_pkg::CFG_SYNC_BYTES:     sync_bytes_q     <= cfg_data[3:0];
					smd_pkg::CFG_MAX_MISMATCHES: max_mismatches_q <= cfg_data[5:0];
					smd_pkg::CFG_FRAME_BYTES:    frame_bytes_q    <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (accept) begin
				sync_window_q <= {sync_window_q[62:0], data_bit};
				bit_s1        <= data_bit;
				valid_s1      <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				in_frame_q        <= in_frame_d;
				frame_bit_count_q <= frame_bit_count_d;
				byte_acc_q        <= byte_acc_d;
				bits_in_byte_q    <= bits_in_byte_d;
			end

			if (push) begin
				desc_q <= desc_new;
			end else if (out_load && pending) begin
				priority if (desc_q.hdr_cnt != 4'd0) begin
					desc_q.hdr_cnt <= desc_q.hdr_cnt - 4'd1;
				end else if (desc_q.has_byte) begin
					desc_q.has_byte <= 1'b0;
				end else begin
					desc_q.has_fill <= 1'b0;
				end
			end

			if (out_load) begin
				result_valid_q <= pending;
			end
		end
	end

	// Output payload holds while stalled.
	always_ff @(posedge clk) begin
		if (out_load && pending) begin
			kind            <= item_kind;
			data_byte       <= item_byte;
			fill_zero_bytes <= item_fill;
			frame_end       <= item_end;
			cut_short       <= item_cut;
		end
	end

	assign result_valid = result_valid_q;

	`SMD_ASSERT(a_bits_track_count, clk, arst_n, bits_in_byte_q == frame_bit_count_q[2:0], "bit position out of step with frame bit count")
	`SMD_ASSERT_IMPL(a_search_clear, clk, arst_n, !in_frame_q, (frame_bit_count_q == '0) && (bits_in_byte_q == 3'd0), "frame state not cleared while searching")
	`SMD_ASSERT_IMPL(a_stall_needs_work, clk, arst_n, bit_stall, valid_s1 && pending, "input stalled without held work")
	`SMD_ASSERT_IMPL(a_fill_marks_cut, clk, arst_n, result_valid && kind, frame_end && cut_short && (data_byte == 8'd0), "fill result without cut frame end")
	`SMD_ASSERT(a_header_bound, clk, arst_n, desc_q.hdr_cnt <= 4'd8, "header count beyond marker length")

endmodule

// File: bench/smd_checker.sv
// Checker for the deframer: predicts byte and zero-fill results from the bit stream and compares.
module smd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        bit_valid,
	input  logic        bit_stall,
	input  logic        data_bit,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic [15:0] fill_zero_bytes,
	input  logic        frame_end,
	input  logic        cut_short,
	output int          mismatches,
	output int          outstanding,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxReports = 10;

	typedef struct packed {
		smd_pkg::kind_t kind;
		logic [7:0]     octet;
		logic [15:0]    fill;
		logic           fend;
		logic           cut;
	} frame_result_t;

	// Register copies.
	logic [63:0] marker_reg;
	logic [3:0]  marker_len_reg;
	logic [5:0]  tolerance_reg;
	logic [15:0] frame_len_reg;

	// Framing state.
	logic [63:0] window;
	logic        locked;
	int unsigned frame_bits_done;
	logic [7:0]  acc;
	int unsigned acc_bits;

	frame_result_t frame_results_q[$];
	frame_result_t want, got;
	int n_bad = 0;
	int n_checked = 0;

	function automatic void queue_result(smd_pkg::kind_t k, logic [7:0] octet,
			logic [15:0] fill, logic fend, logic cut);
		frame_result_t r;
		r.kind  = k;
		r.octet = octet;
		r.fill  = fill;
		r.fend  = fend;
		r.cut   = cut;
		frame_results_q = {frame_results_q, r};
	endfunction

	task automatic restart_frame();
		frame_bits_done = 0;
		acc = '0;
		acc_bits = 0;
	endtask

	// One stream bit through the synchronizer.
	task automatic take_bit(input logic b);
		int unsigned sb, fb, fbits, used, fill;
		int i;
		logic [63:0] mask;
		logic [7:0]  padded;
		logic        hit, last;
		sb = marker_len_reg;
		if (sb == 0) sb = 1;
		if (sb > 8) sb = 8;
		fb = frame_len_reg;
		if (fb <= sb) fb = sb + 1;
		fbits = fb * 8;
		mask = (sb == 8) ? '1 : ((64'd1 << (sb * 8)) - 64'd1);
		window = {window[62:0], b};
		hit = $countones((window ^ marker_reg) & mask) <= tolerance_reg;

		if (!locked) begin
			if (hit) locked = 1'b1;
			return;
		end

		// First bit of a frame: the clean marker goes out as header bytes.
		if (frame_bits_done == 0) begin
			for (i = sb; i > 0; i--)
				queue_result(smd_pkg::KIND_DATA, 8'(marker_reg >> ((i - 1) * 8)), '0,
					1'b0, 1'b0);
			frame_bits_done = sb * 8;
			acc = '0;
			acc_bits = 0;
		end

		// A marker inside a frame cuts it; the completing bit is dropped.
		if (hit) begin
			used = frame_bits_done;
			fill = 0;
			if (acc_bits != 0) begin
				padded = acc << (8 - acc_bits);
				queue_result(smd_pkg::KIND_DATA, padded, '0, 1'b0, 1'b0);
				used += 8 - acc_bits;
			end
			if (used < fbits) fill = (fbits - used) / 8;
			queue_result(smd_pkg::KIND_FILL, '0, 16'(fill), 1'b1, 1'b1);
			restart_frame();
			return;
		end

		acc = {acc[6:0], b};
		acc_bits++;
		frame_bits_done++;
		last = frame_bits_done >= fbits;
		if (acc_bits >= 8) begin
			queue_result(smd_pkg::KIND_DATA, acc, '0, last, 1'b0);
			acc = '0;
			acc_bits = 0;
		end else if (last) begin
			padded = acc << (8 - acc_bits);
			queue_result(smd_pkg::KIND_DATA, padded, '0, 1'b1, 1'b0);
		end
		if (last) begin
			locked = 1'b0;
			restart_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_reg     = smd_pkg::SyncPatternReset;
			marker_len_reg = smd_pkg::SyncBytesReset;
			tolerance_reg  = smd_pkg::MaxMismatchesReset;
			frame_len_reg  = smd_pkg::FrameBytesReset;
			window         = '0;
			locked         = 1'b0;
			restart_frame();
			frame_results_q.delete();
		end else begin
			if (result_valid && !result_stall) begin
				got = {smd_pkg::kind_t'(kind), data_byte, fill_zero_bytes, frame_end, cut_short};
				if (frame_results_q.size() == 0) begin
					n_bad++;
					if (n_bad <= MaxReports)
						$display("%0t: unexpected result kind %0d byte %02h fill %0d end %0b cut %0b",
							$realtime, got.kind, got.octet, got.fill, got.fend, got.cut);
				end else begin
					want = frame_results_q.pop_front();
					n_checked++;
					if (want !== got) begin
						n_bad++;
						if (n_bad <= MaxReports)
							$display({"%0t: result %0d differs: expected kind %0d byte %02h fill %0d ",
								"end %0b cut %0b, got kind %0d byte %02h fill %0d end %0b cut %0b"},
								$realtime, n_checked, want.kind, want.octet, want.fill, want.fend,
								want.cut, got.kind, got.octet, got.fill, got.fend, got.cut);
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					smd_pkg::CFG_SYNC_PATTERN:   marker_reg = cfg_data;
					smd_pkg::CFG_SYNC_BYTES:     marker_len_reg = cfg_data[3:0];
					smd_pkg::CFG_MAX_MISMATCHES: tolerance_reg = cfg_data[5:0];
					smd_pkg::CFG_FRAME_BYTES:    frame_len_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (bit_valid && !bit_stall)
				take_bit(data_bit);
		end
		mismatches  <= n_bad;
		outstanding <= frame_results_q.size();
		checked     <= n_checked;
	end

endmodule

// File: bench/tb_top.sv
// Top of the deframer bench: clock, reset, bit stream and register stimulus, verdict.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	// Longest run of cycles without any handshake before the run is declared hung.
	// The deliberate receiver hold-off is far shorter than this limit, random stalls are short.
	localparam int StallLimit = 3000;
	localparam int HoldCycles = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	smd_pkg::cfg_index_t cfg_index = smd_pkg::CFG_SYNC_PATTERN;
	logic [63:0] cfg_data = '0;
	logic        bit_valid = 1'b0;
	logic        bit_stall;
	logic        data_bit = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [15:0] fill_zero_bytes;
	logic        frame_end;
	logic        cut_short;

	int mismatches;
	int outstanding;
	int checked;

	// Bench-side bookkeeping; no_idle and hold_asks are shared between the stimulus and the receiver.
	bit no_idle = 1'b0;
	int hold_asks = 0;
	int bits_sent = 0;
	int settings_written = 0;

	sync_marker_bit_deframer dut (.*);

	smd_checker checker_i (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side. Stalls at random about a third of the time, except during a
	// no-idle stretch. When the stimulus asks for a hold-off, the receiver keeps
	// stall high for a long, fixed stretch so the block backs up into its input.
	initial begin : receiver
		int holds_served;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_served) begin
				holds_served = hold_asks;
				result_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
			end
			result_stall <= !no_idle && ($urandom_range(99) < 33);
		end
	end

	// Any handshake or register write counts as progress.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((bit_valid && !bit_stall) || (result_valid && !result_stall) || cfg_wr_en
					|| !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no handshake for %0d cycles, %0d results still due",
			StallLimit, outstanding);
		$display("Mismatches found");
		$finish;
	end

	// Offer one bit and hold it until the block takes the beat. Idle cycles are
	// inserted before the offer, never while a beat is pending.
	task automatic send_bit(input logic b);
		while (!no_idle && $urandom_range(99) < 33) begin
			bit_valid <= 1'b0;
			@(posedge clk);
		end
		bit_valid <= 1'b1;
		data_bit  <= b;
		do @(posedge clk); while (bit_stall);
		bits_sent++;
	endtask

	// Stream the low n bits of v, most significant first.
	task automatic send_bits(input logic [63:0] v, input int n);
		int i;
		for (i = n - 1; i >= 0; i--)
			send_bit(v[i]);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_bit(1'($urandom_range(1)));
	endtask

	// A marker of nbytes bytes with exactly nerr distinct bits flipped.
	task automatic send_marker(input logic [63:0] pat, input int nbytes, input int nerr);
		logic [63:0] flips;
		int nbits;
		nbits = nbytes * 8;
		flips = '0;
		while ($countones(flips) < nerr)
			flips[$urandom_range(nbits - 1)] = 1'b1;
		send_bits(pat ^ flips, nbits);
	endtask

	// Quiesce: stop offering bits, wait until every predicted result has been
	// taken, then give the block a few more cycles in case the last bit is still
	// working its way through without producing a result.
	task automatic settle();
		bit_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	// Write all four registers back to back. The unused upper data bits carry
	// random junk, which the block must ignore.
	task automatic set_regs(input logic [63:0] pat, input logic [3:0] sb, input logic [5:0] mm,
			input logic [15:0] fb);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_wr_en <= 1'b1;
		cfg_index <= smd_pkg::CFG_SYNC_PATTERN;
		cfg_data  <= pat;
		@(posedge clk);
		cfg_index <= smd_pkg::CFG_SYNC_BYTES;
		cfg_data  <= {junk[63:4], sb};
		@(posedge clk);
		cfg_index <= smd_pkg::CFG_MAX_MISMATCHES;
		cfg_data  <= {junk[63:6], mm};
		@(posedge clk);
		cfg_index <= smd_pkg::CFG_FRAME_BYTES;
		cfg_data  <= {junk[63:16], fb};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_written++;
	endtask

	initial begin : stimulus
		logic [63:0] pat;
		int sbv, sbe, mmv, fbv, fbe, room, lim, nerr, nframes, dlen, r, phase;
		int start_checked;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a full 64-bit marker at the tolerance of nine locks and
		// opens the long default frame. Then the frame length drops below what the
		// open frame already holds. The shortened length is also below the marker,
		// so it acts as the marker plus one byte, and the next bit ends the frame
		// with a padded byte.
		send_noise(4);
		send_marker(smd_pkg::SyncPatternReset, 8, 9);
		send_noise(10);
		settle();
		set_regs(smd_pkg::SyncPatternReset, smd_pkg::SyncBytesReset,
			smd_pkg::MaxMismatchesReset, 16'd2);
		send_noise(1);

		// Zero marker length acts as one byte; marker 0xFF, no tolerance, three
		// byte frames. Lock, send a 0x00 byte, then a marker whose leading seven
		// ones fill the last byte: the cut has nothing missing. Further ones hit
		// the marker on the first frame bit again and again. This and the next
		// part run without any idling on either side.
		settle();
		set_regs('1, 4'd0, 6'd0, 16'd3);
		no_idle = 1'b1;
		send_bits(64'h00, 8);
		send_bits(64'hFF, 8);
		send_bits(64'h00, 8);
		send_bits(64'hFF, 8);
		send_bits(64'h3, 2);

		// Marker length 15 acts as eight bytes; a tolerance of 63 matches all but
		// an all-ones window, so each bit emits a full header and a cut: the most
		// results any one bit can cause. Frame length zero acts as the marker plus
		// one byte.
		settle();
		set_regs('0, 4'd15, 6'd63, 16'd0);
		send_noise(5);
		settle();
		no_idle = 1'b0;

		// Back-pressure: the receiver holds off while bits keep coming, so the
		// result buffer fills and the block has to stall its bit input.
		pat = {$urandom, $urandom};
		set_regs(pat, 4'd2, 6'd1, 16'd40);
		hold_asks++;
		send_marker(pat, 2, 1);
		send_noise(16);

		// Random phases. Each picks fresh settings, leaning toward short markers
		// and short frames, and then sends one or two marker-plus-payload sequences.
		// Most markers sit within the tolerance; some are broken on purpose, some
		// payloads run to the end of the frame and others are cut by the next
		// marker, now and then right on the first frame bit.
		start_checked = checked;
		phase = 0;
		while (bits_sent < 180 && phase < 20) begin
			settle();
			r = $urandom_range(9);
			pat = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
			r = $urandom_range(9);
			sbv = (r < 7) ? $urandom_range(1, 3) : (r == 7) ? $urandom_range(4, 8)
				: $urandom_range(0, 15);
			sbe = (sbv == 0) ? 1 : (sbv > 8) ? 8 : sbv;
			mmv = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, sbe * 2);
			r = $urandom_range(19);
			fbv = (r == 0) ? 16'hFFFF : (r == 1) ? $urandom_range(0, 3)
				: $urandom_range(sbe + 1, sbe + 4);
			fbe = (fbv <= sbe) ? sbe + 1 : fbv;
			room = fbe * 8 - sbe * 8;
			if (room > 24) room = 24;
			set_regs(pat, 4'(sbv), 6'(mmv), 16'(fbv));

			send_noise($urandom_range(0, 6));
			nframes = $urandom_range(1, 2);
			repeat (nframes) begin
				lim = (mmv < sbe * 8) ? mmv : sbe * 8;
				if ($urandom_range(9) < 8 || mmv + 1 > sbe * 8)
					nerr = $urandom_range(0, lim);
				else
					nerr = mmv + 1;
				send_marker(pat, sbe, nerr);
				r = $urandom_range(9);
				dlen = (r < 6) ? room : (r < 9) ? $urandom_range(0, room) : 0;
				send_noise(dlen);
			end
			phase++;
		end

		// Drain everything still due, then allow for the block's latency.
		bit_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);

		$display("Covered %0d stream bits under %0d register settings (%0d random phases).",
			bits_sent, settings_written, phase);
		$display("Checked %0d byte and zero-fill results, %0d of them after the directed part.",
			checked, checked - start_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/smd_pkg.sv
hdl/sync_marker_bit_deframer.sv
bench/smd_checker.sv
bench/tb_top.sv
